>>> design/pcs_pkg.sv
// shared widths for the prime count sieve
package pcs_pkg;

  localparam int IN_W   = 16;  // upper limit word
  localparam int OUT_W  = 13;  // prime total word
  localparam int LIST_W = 8;   // small prime list entry

endpackage

>>> design/pcs_ram.sv
// generic simple dual-port ram, one write port and one registered read port
module pcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/prime_count_sieve.sv
// prime counter: per word, clears the bitmap up to n, sieves 2..isqrt(n), counts the rest
// throughput: one word at a time, set by the single bitmap memory (one write, one read a cycle)
// reset: synchronous active-low, clears control only; the bitmap is cleared up to n at each request with n of 2 or more
module prime_count_sieve #(
  parameter int MAX_LIMIT         = 65535,
  parameter int SMALL_PRIME_SLOTS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [pcs_pkg::IN_W-1:0]   in_upper_limit,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [pcs_pkg::OUT_W-1:0]  out_prime_total
);

  import pcs_pkg::*;

  localparam int AW = $clog2(MAX_LIMIT + 1);
  localparam int VW = AW + 1;
  localparam int SW = $clog2(SMALL_PRIME_SLOTS + 1);
  localparam int LW = $clog2(SMALL_PRIME_SLOTS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_TEST  = 3'd3;
  localparam logic [2:0] S_MARK  = 3'd4;
  localparam logic [2:0] S_COUNT = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [AW-1:0]    n_r, n_nxt;
  logic [VW-1:0]    i_r, i_nxt;
  logic [VW-1:0]    sq_r, sq_nxt;
  logic [VW-1:0]    j_r, j_nxt;
  logic [OUT_W-1:0] total_r, total_nxt;
  logic [SW-1:0]    slots_r, slots_nxt;
  logic             pend_r, pend_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_total_r, out_total_nxt;

  logic             map_we;
  logic [AW-1:0]    map_waddr;
  logic [0:0]       map_wdata;
  logic             map_re;
  logic [AW-1:0]    map_raddr;
  logic [0:0]       map_rdata;
  logic             list_we;

  logic [31:0]      in_ext;
  logic [AW-1:0]    n_in;
  logic [VW-1:0]    n_ext;

  // saturate the limit to the bitmap size
  assign in_ext = 32'(in_upper_limit);
  assign n_in   = (in_ext > 32'(MAX_LIMIT)) ? AW'(MAX_LIMIT) : AW'(in_ext);
  assign n_ext  = {1'b0, n_r};

  pcs_ram #(
    .WIDTH (1),
    .DEPTH (MAX_LIMIT + 1)
  ) u_map (
    .clk     (clk),
    .wr_en   (map_we),
    .wr_addr (map_waddr),
    .wr_data (map_wdata),
    .rd_en   (map_re),
    .rd_addr (map_raddr),
    .rd_data (map_rdata)
  );

  pcs_ram #(
    .WIDTH (LIST_W),
    .DEPTH (SMALL_PRIME_SLOTS)
  ) u_list (
    .clk     (clk),
    .wr_en   (list_we),
    .wr_addr (slots_r[LW-1:0]),
    .wr_data (i_r[LIST_W-1:0]),
    .rd_en   (1'b0),
    .rd_addr ({LW{1'b0}}),
    .rd_data ()
  );

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    sq_nxt        = sq_r;
    j_nxt         = j_r;
    total_nxt     = total_r;
    slots_nxt     = slots_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    out_total_nxt = out_total_r;
    map_we        = 1'b0;
    map_waddr     = j_r[AW-1:0];
    map_wdata     = 1'b0;
    map_re        = 1'b0;
    map_raddr     = i_r[AW-1:0];
    list_we       = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          n_nxt     = n_in;
          total_nxt = '0;
          slots_nxt = '0;
          j_nxt     = '0;
          state_nxt = (n_in < AW'(2)) ? S_DONE : S_CLEAR;
        end
      end
      S_CLEAR: begin
        map_we = 1'b1;
        if (j_r[AW-1:0] == n_r) begin
          i_nxt     = VW'(2);
          sq_nxt    = VW'(4);
          state_nxt = S_CHECK;
        end else begin
          j_nxt = j_r + VW'(1);
        end
      end
      S_CHECK: begin
        if (sq_r > n_ext) begin
          pend_nxt  = 1'b0;
          state_nxt = S_COUNT;
        end else begin
          map_re    = 1'b1;
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        if (map_rdata[0]) begin
          i_nxt     = i_r + VW'(1);
          sq_nxt    = sq_r + (i_r << 1) + VW'(1);
          state_nxt = S_CHECK;
        end else begin
          total_nxt = total_r + OUT_W'(1);
          if (slots_r < SW'(SMALL_PRIME_SLOTS)) begin
            list_we   = 1'b1;
            slots_nxt = slots_r + SW'(1);
          end
          j_nxt     = sq_r;
          state_nxt = S_MARK;
        end
      end
      S_MARK: begin
        if (j_r > n_ext) begin
          i_nxt     = i_r + VW'(1);
          sq_nxt    = sq_r + (i_r << 1) + VW'(1);
          state_nxt = S_CHECK;
        end else begin
          map_we    = 1'b1;
          map_wdata = 1'b1;
          j_nxt     = j_r + i_r;
        end
      end
      S_COUNT: begin
        // read one value a cycle, score the one read last cycle
        if (pend_r && !map_rdata[0]) begin
          total_nxt = total_r + OUT_W'(1);
        end
        if (i_r <= n_ext) begin
          map_re   = 1'b1;
          i_nxt    = i_r + VW'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_total_nxt = total_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    i_r         <= i_nxt;
    sq_r        <= sq_nxt;
    j_r         <= j_nxt;
    total_r     <= total_nxt;
    slots_r     <= slots_nxt;
    out_total_r <= out_total_nxt;
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_prime_total = out_total_r;

endmodule
